// ===== hdl/ita_pkg.sv =====
// ----------------------------------------------------------------------------
// ita_pkg: shared types and constants for the decimal ASCII converter
// Holds the item types of both channels, the control bundle for the digit
// unit and the widths that follow from the value width.
// ----------------------------------------------------------------------------
package ita_pkg;

    // Width of the value field; fixed by the input item format.
    localparam int VALUE_WIDTH = 32;

    // Decimal digits needed for the widest unsigned value (log10(2) ~ 0.301).
    localparam int NUM_DIGITS  = (VALUE_WIDTH * 301) / 1000 + 1;
    localparam int BCD_WIDTH   = 4 * NUM_DIGITS;
    localparam int CNT_WIDTH   = $clog2(VALUE_WIDTH + 1);
    localparam int NDIG_WIDTH  = $clog2(NUM_DIGITS + 1);

    localparam logic [7:0] ASCII_ZERO  = 8'd48;
    localparam logic [7:0] ASCII_MINUS = 8'd45;

    typedef struct packed {
        logic                   mode;
        logic [VALUE_WIDTH-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic [7:0] character;
        logic       last;
    } t_out_item;

    // Commands from the sequencer to the digit unit.
    typedef struct packed {
        logic load;         // take a new magnitude, clear the digits
        logic dabble;       // one shift-add-3 step
        logic digit_shift;  // move the digits up by one place
    } t_unit_ctl;

endpackage

// ===== hdl/ita_digit_unit.sv =====
// ----------------------------------------------------------------------------
// ita_digit_unit: shift-add-3 binary to BCD unit
// One shared step converts one binary bit per cycle into packed BCD digits;
// the same register then shifts digits out from the most significant end.
// ----------------------------------------------------------------------------
module ita_digit_unit (
    input  logic                             i_clk,
    input  ita_pkg::t_unit_ctl               i_ctl,
    input  logic [ita_pkg::VALUE_WIDTH-1:0]  i_load_value,
    output logic [3:0]                       o_top_digit
);

    logic [ita_pkg::VALUE_WIDTH-1:0] r_bin;
    logic [ita_pkg::BCD_WIDTH-1:0]   r_bcd;
    logic [ita_pkg::BCD_WIDTH-1:0]   w_adj;

    // Every digit of five or more gets three added before the shift.
    always_comb begin
        for (int d = 0; d < ita_pkg::NUM_DIGITS; d++) begin
            if (r_bcd[4*d +: 4] >= 4'd5) begin
                w_adj[4*d +: 4] = r_bcd[4*d +: 4] + 4'd3;
            end else begin
                w_adj[4*d +: 4] = r_bcd[4*d +: 4];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_bin <= i_load_value;
            r_bcd <= '0;
        end else if (i_ctl.dabble) begin
            r_bcd <= {w_adj[ita_pkg::BCD_WIDTH-2:0], r_bin[ita_pkg::VALUE_WIDTH-1]};
            r_bin <= {r_bin[ita_pkg::VALUE_WIDTH-2:0], 1'b0};
        end else if (i_ctl.digit_shift) begin
            r_bcd <= {r_bcd[ita_pkg::BCD_WIDTH-5:0], 4'd0};
        end
    end

    assign o_top_digit = r_bcd[ita_pkg::BCD_WIDTH-1 -: 4];

endmodule

// ===== hdl/integer_to_decimal_ascii_top.sv =====
// ----------------------------------------------------------------------------
// integer_to_decimal_ascii_top: binary to decimal ASCII converter
// Busy: no new item is taken while busy, which covers the 32-step
//   shift-add-3 loop, the leading-zero scan and the digit emission.
// Output: a '-' appears in the cycle after acceptance, the digits after the
//   conversion and the leading-zero scan, then one character a cycle.
// Reset: synchronous, active low; clears the sequencer and the result strobe.
// The receiver cannot stall; each character is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module integer_to_decimal_ascii_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  ita_pkg::t_in_item  i_item,
    output logic               busy,
    output logic               o_strobe,
    output ita_pkg::t_out_item o_result
);

    // Sequencer: load, then one conversion step per value bit, then strip
    // leading zero digits one per cycle, then emit one digit per cycle.
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CONV = 4'b0010,
        S_SCAN = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    t_state r_state, n_state;

    logic [ita_pkg::CNT_WIDTH-1:0]  r_cnt, n_cnt;
    logic [ita_pkg::NDIG_WIDTH-1:0] r_ndig, n_ndig;
    logic                           r_strobe, n_strobe;
    ita_pkg::t_out_item             r_out, n_out;

    ita_pkg::t_unit_ctl              w_ctl;
    logic [3:0]                      w_top_digit;
    logic [ita_pkg::VALUE_WIDTH-1:0] w_mag;
    logic                            w_neg;
    logic                            w_accept;

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;

    // In signed mode a set sign bit means negative; the magnitude of the most
    // negative value wraps to itself, which is exactly its unsigned magnitude.
    assign w_neg = i_item.mode && i_item.value[ita_pkg::VALUE_WIDTH-1];
    assign w_mag = w_neg ? (~i_item.value + 1'b1) : i_item.value;

    ita_digit_unit u_digit (
        .i_clk        (i_clk),
        .i_ctl        (w_ctl),
        .i_load_value (w_mag),
        .o_top_digit  (w_top_digit)
    );

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_ndig   = r_ndig;
        n_strobe = 1'b0;
        n_out    = r_out;
        w_ctl    = '0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    w_ctl.load = 1'b1;
                    n_cnt      = '0;
                    n_ndig     = ita_pkg::NDIG_WIDTH'(ita_pkg::NUM_DIGITS);
                    n_state    = S_CONV;
                    // The sign goes out right away; it is never the last one.
                    if (w_neg) begin
                        n_strobe        = 1'b1;
                        n_out.character = ita_pkg::ASCII_MINUS;
                        n_out.last      = 1'b0;
                    end
                end
            end
            S_CONV: begin
                w_ctl.dabble = 1'b1;
                n_cnt        = r_cnt + 1'b1;
                if (r_cnt == ita_pkg::CNT_WIDTH'(ita_pkg::VALUE_WIDTH - 1)) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                // Drop leading zeros, but always keep the ones digit.
                if (w_top_digit == 4'd0 && r_ndig > ita_pkg::NDIG_WIDTH'(1)) begin
                    w_ctl.digit_shift = 1'b1;
                    n_ndig            = r_ndig - 1'b1;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                w_ctl.digit_shift = 1'b1;
                n_strobe          = 1'b1;
                n_out.character   = ita_pkg::ASCII_ZERO + {4'd0, w_top_digit};
                n_out.last        = (r_ndig == ita_pkg::NDIG_WIDTH'(1));
                n_ndig            = r_ndig - 1'b1;
                if (r_ndig == ita_pkg::NDIG_WIDTH'(1)) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt  <= n_cnt;
        r_ndig <= n_ndig;
        r_out  <= n_out;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_out;

    // Every character shown is a minus sign or a decimal digit.
    a_char_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_result.character == ita_pkg::ASCII_MINUS ||
                      (o_result.character >= ita_pkg::ASCII_ZERO &&
                       o_result.character <= ita_pkg::ASCII_ZERO + 8'd9)))
        else $error("illegal character on result port");

    // A minus sign never ends a number.
    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.character == ita_pkg::ASCII_MINUS) |-> !o_result.last)
        else $error("minus sign flagged as last character");

    // The last character leaves as the sequencer returns to idle.
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.last) |-> !busy)
        else $error("last character while still busy");

    // An accepted item keeps the block busy through its conversion.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && !(o_strobe && o_result.last)))
        else $error("block not busy after accepting an item");

endmodule
